// ===== hdl/csb_pkg.sv =====
// ---------------------------------------------------------------------------
// Counting semaphore bank package
// Shared widths, codes, command and table entry types, and count clamping
// functions for the semaphore bank.
// ---------------------------------------------------------------------------
package csb_pkg;

   localparam int NUM_SEMS       = 64;
   localparam int WAIT_DEPTH     = 64;
   localparam int THREAD_ID_BITS = 8;
   localparam int COUNT_BITS     = 16;

   localparam int OP_BITS     = 2;
   localparam int ID_BITS     = 6;
   localparam int VAL_BITS    = 16;
   localparam int STATUS_BITS = 3;
   localparam int TID_BITS    = 8;

   localparam int IDX_BITS    = $clog2(NUM_SEMS);
   localparam int WAIT_BITS   = $clog2(WAIT_DEPTH);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

   localparam logic signed [COUNT_BITS-1:0] COUNT_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};

   typedef enum logic [OP_BITS-1:0] {
      OP_CREATE = 2'd0,
      OP_UP     = 2'd1,
      OP_DOWN   = 2'd2,
      OP_QUERY  = 2'd3
   } op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK          = 3'd0,
      ST_BAD_ID      = 3'd1,
      ST_TABLE_FULL  = 3'd2,
      ST_QUEUE_EMPTY = 3'd3,
      ST_QUEUE_FULL  = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      KIND_CREATE,
      KIND_FULL,
      KIND_BAD_ID,
      KIND_UP,
      KIND_DOWN,
      KIND_QUERY
   } kind_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_READ,
      BK_EXEC
   } back_state_type;

   typedef struct packed {
      kind_type                    kind;
      logic [IDX_BITS-1:0]         idx;
      logic [ID_BITS-1:0]          rid;
      logic signed [VAL_BITS-1:0]  max_count;
      logic signed [VAL_BITS-1:0]  init_value;
      logic                        soft_mode;
      logic [THREAD_ID_BITS-1:0]   thread;
   } cmd_type;

   typedef struct packed {
      logic signed [COUNT_BITS-1:0] count;
      logic signed [COUNT_BITS-1:0] max;
      logic                         soft_mode;
   } sem_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic signed [COUNT_BITS-1:0] clamp_in(
      input logic signed [VAL_BITS-1:0] v);
      logic signed [47:0] w;
      logic signed [47:0] hi;
      logic signed [47:0] lo;
      hi = (48'sd1 <<< (COUNT_BITS - 1)) - 48'sd1;
      lo = -(48'sd1 <<< (COUNT_BITS - 1));
      w  = 48'(v);
      if (w > hi) begin
         w = hi;
      end else if (w < lo) begin
         w = lo;
      end
      return w[COUNT_BITS-1:0];
   endfunction

   function automatic logic [VAL_BITS-1:0] clamp_out(
      input logic signed [COUNT_BITS-1:0] v);
      logic signed [47:0] w;
      logic signed [47:0] hi;
      logic signed [47:0] lo;
      hi = (48'sd1 <<< (VAL_BITS - 1)) - 48'sd1;
      lo = -(48'sd1 <<< (VAL_BITS - 1));
      w  = 48'(v);
      if (w > hi) begin
         w = hi;
      end else if (w < lo) begin
         w = lo;
      end
      return w[VAL_BITS-1:0];
   endfunction

endpackage

// ===== hdl/csb_front.sv =====
// ---------------------------------------------------------------------------
// Semaphore bank front end
// Accepts commands, hands out ids, checks ids against the created set and
// classifies each beat before it enters the command queue.
// ---------------------------------------------------------------------------
module csb_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  accept,
   input  logic [csb_pkg::OP_BITS-1:0]           req_op,
   input  logic [csb_pkg::ID_BITS-1:0]           req_sem_id,
   input  logic signed [csb_pkg::VAL_BITS-1:0]   req_max_count,
   input  logic signed [csb_pkg::VAL_BITS-1:0]   req_init_value,
   input  logic                                  req_soft_flag,
   input  logic [csb_pkg::TID_BITS-1:0]          req_thread_id,
   output logic                                  push,
   output csb_pkg::cmd_type                      cmd
);
   import csb_pkg::*;

   logic [NUM_SEMS-1:0] sem_valid_ff;
   logic [NUM_SEMS-1:0] sem_valid_in;
   logic [IDX_BITS:0]   next_id_ff;
   logic [IDX_BITS:0]   next_id_in;
   logic [31:0]         id_ext;
   logic [IDX_BITS-1:0] id_idx;
   logic                id_ok;
   logic                table_full;
   op_type              op;

   assign op         = op_type'(req_op);
   assign id_ext     = 32'(req_sem_id);
   assign id_idx     = id_ext[IDX_BITS-1:0];
   assign id_ok      = (id_ext < 32'(NUM_SEMS)) && sem_valid_ff[id_idx];
   assign table_full = (32'(next_id_ff) == 32'(NUM_SEMS));
   assign push       = accept;

   always_comb begin
      sem_valid_in   = sem_valid_ff;
      next_id_in     = next_id_ff;
      cmd.kind       = KIND_QUERY;
      cmd.idx        = id_idx;
      cmd.rid        = req_sem_id;
      cmd.max_count  = req_max_count;
      cmd.init_value = req_init_value;
      cmd.soft_mode  = req_soft_flag;
      cmd.thread     = req_thread_id[THREAD_ID_BITS-1:0];
      case (op)
         OP_CREATE: begin
            if (table_full) begin
               cmd.kind = KIND_FULL;
               cmd.rid  = '0;
            end else begin
               cmd.kind = KIND_CREATE;
               cmd.idx  = next_id_ff[IDX_BITS-1:0];
               cmd.rid  = ID_BITS'(next_id_ff);
               if (accept) begin
                  sem_valid_in[next_id_ff[IDX_BITS-1:0]] = 1'b1;
                  next_id_in = next_id_ff + 1'b1;
               end
            end
         end
         OP_UP:    cmd.kind = id_ok ? KIND_UP : KIND_BAD_ID;
         OP_DOWN:  cmd.kind = id_ok ? KIND_DOWN : KIND_BAD_ID;
         OP_QUERY: cmd.kind = id_ok ? KIND_QUERY : KIND_BAD_ID;
         default:  cmd.kind = KIND_BAD_ID;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sem_valid_ff <= '0;
         next_id_ff   <= '0;
      end else begin
         sem_valid_ff <= sem_valid_in;
         next_id_ff   <= next_id_in;
      end
   end

endmodule

// ===== hdl/csb_queue.sv =====
// ---------------------------------------------------------------------------
// Semaphore bank command queue
// Short queue of classified commands between the front end and the back end.
// ---------------------------------------------------------------------------
module csb_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  csb_pkg::cmd_type           push_cmd,
   input  logic                       pop,
   output csb_pkg::cmd_type           pop_cmd,
   output csb_pkg::queue_status_type  qstat
);
   import csb_pkg::*;

   cmd_type              entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff;
   logic [QPTR_BITS-1:0] wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff;
   logic [QPTR_BITS-1:0] rd_ptr_in;
   logic [QPTR_BITS:0]   fill_ff;
   logic [QPTR_BITS:0]   fill_in;

   assign qstat.full  = (32'(fill_ff) == 32'(QUEUE_DEPTH));
   assign qstat.empty = (fill_ff == '0);
   assign pop_cmd     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) !(push && qstat.full))
      else $error("Command pushed into a full queue.");
   assert property (@(posedge clock) disable iff (reset) !(pop && qstat.empty))
      else $error("Command popped from an empty queue.");
   assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (fill_ff == $past(fill_ff) + 1'b1))
      else $error("Queue fill did not follow a lone push.");

endmodule

// ===== hdl/csb_back.sv =====
// ---------------------------------------------------------------------------
// Semaphore bank back end
// Executes classified commands against the semaphore table and the shared
// wait queue, and registers one result per command.
// ---------------------------------------------------------------------------
module csb_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  csb_pkg::queue_status_type             qstat,
   input  csb_pkg::cmd_type                      q_cmd,
   output logic                                  pop,
   output logic                                  rsp_strobe,
   output logic [csb_pkg::STATUS_BITS-1:0]       rsp_status,
   output logic [csb_pkg::ID_BITS-1:0]           rsp_result_id,
   output logic signed [csb_pkg::VAL_BITS-1:0]   rsp_count,
   output logic                                  rsp_is_soft,
   output logic                                  rsp_caller_blocks,
   output logic                                  rsp_wake_valid,
   output logic [csb_pkg::TID_BITS-1:0]          rsp_wake_thread
);
   import csb_pkg::*;

   back_state_type state_ff;
   back_state_type state_in;
   logic           do_read;
   logic           do_exec;

   cmd_type                    cmd_ff;
   sem_entry_type              table_mem [NUM_SEMS];
   logic [THREAD_ID_BITS-1:0]  wait_mem [WAIT_DEPTH];
   sem_entry_type              rd_entry_ff;
   logic [THREAD_ID_BITS-1:0]  head_data_ff;

   logic [WAIT_BITS-1:0] head_ff;
   logic [WAIT_BITS-1:0] head_in;
   logic [WAIT_BITS-1:0] tail_ff;
   logic [WAIT_BITS-1:0] tail_in;
   logic [WAIT_BITS:0]   fill_ff;
   logic [WAIT_BITS:0]   fill_in;

   sem_entry_type              wr_entry;
   logic                       table_we;
   logic                       wait_we;
   logic signed [COUNT_BITS-1:0] cnt_up;
   logic signed [COUNT_BITS-1:0] cnt_dn;

   status_type                 res_status;
   logic [ID_BITS-1:0]         res_rid;
   logic [VAL_BITS-1:0]        res_count;
   logic                       res_soft;
   logic                       res_blk;
   logic                       res_wv;
   logic [TID_BITS-1:0]        res_wt;

   logic                       rsp_strobe_ff;
   logic [STATUS_BITS-1:0]     rsp_status_ff;
   logic [ID_BITS-1:0]         rsp_result_id_ff;
   logic [VAL_BITS-1:0]        rsp_count_ff;
   logic                       rsp_is_soft_ff;
   logic                       rsp_caller_blocks_ff;
   logic                       rsp_wake_valid_ff;
   logic [TID_BITS-1:0]        rsp_wake_thread_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: state_in = qstat.empty ? BK_IDLE : BK_READ;
         BK_READ: state_in = BK_EXEC;
         BK_EXEC: state_in = BK_IDLE;
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      pop     = 1'b0;
      do_read = 1'b0;
      do_exec = 1'b0;
      case (state_ff)
         BK_IDLE: pop     = !qstat.empty;
         BK_READ: do_read = 1'b1;
         BK_EXEC: do_exec = 1'b1;
         default: pop     = 1'b0;
      endcase
   end

   assign cnt_up = (rd_entry_ff.count < rd_entry_ff.max) ?
                   rd_entry_ff.count + COUNT_BITS'(1) : rd_entry_ff.count;
   assign cnt_dn = (rd_entry_ff.count != COUNT_MIN) ?
                   rd_entry_ff.count - COUNT_BITS'(1) : rd_entry_ff.count;

   always_comb begin
      wr_entry   = rd_entry_ff;
      table_we   = 1'b0;
      wait_we    = 1'b0;
      head_in    = head_ff;
      tail_in    = tail_ff;
      fill_in    = fill_ff;
      res_status = ST_OK;
      res_rid    = cmd_ff.rid;
      res_count  = clamp_out(rd_entry_ff.count);
      res_soft   = rd_entry_ff.soft_mode;
      res_blk    = 1'b0;
      res_wv     = 1'b0;
      res_wt     = '0;
      case (cmd_ff.kind)
         KIND_CREATE: begin
            wr_entry.count     = clamp_in(cmd_ff.init_value);
            wr_entry.max       = clamp_in(cmd_ff.max_count);
            wr_entry.soft_mode = cmd_ff.soft_mode;
            table_we           = do_exec;
            res_count          = clamp_out(wr_entry.count);
            res_soft           = cmd_ff.soft_mode;
         end
         KIND_FULL: begin
            res_status = ST_TABLE_FULL;
            res_count  = '0;
            res_soft   = 1'b0;
         end
         KIND_BAD_ID: begin
            res_status = ST_BAD_ID;
            res_count  = '0;
            res_soft   = 1'b0;
         end
         KIND_UP: begin
            wr_entry.count = cnt_up;
            table_we       = do_exec;
            res_count      = clamp_out(cnt_up);
            if (!rd_entry_ff.soft_mode && (cnt_up[COUNT_BITS-1] || cnt_up == '0)) begin
               if (fill_ff == '0) begin
                  res_status = ST_QUEUE_EMPTY;
               end else begin
                  res_wv = 1'b1;
                  res_wt = TID_BITS'(head_data_ff);
                  if (do_exec) begin
                     head_in = (32'(head_ff) == WAIT_DEPTH - 1) ? '0 : head_ff + 1'b1;
                     fill_in = fill_ff - 1'b1;
                  end
               end
            end
         end
         KIND_DOWN: begin
            wr_entry.count = cnt_dn;
            table_we       = do_exec;
            res_count      = clamp_out(cnt_dn);
            if (!rd_entry_ff.soft_mode && cnt_dn[COUNT_BITS-1]) begin
               if (32'(fill_ff) == 32'(WAIT_DEPTH)) begin
                  res_status = ST_QUEUE_FULL;
               end else begin
                  res_blk = 1'b1;
                  wait_we = do_exec;
                  if (do_exec) begin
                     tail_in = (32'(tail_ff) == WAIT_DEPTH - 1) ? '0 : tail_ff + 1'b1;
                     fill_in = fill_ff + 1'b1;
                  end
               end
            end
         end
         KIND_QUERY: res_status = ST_OK;
         default:    res_status = ST_BAD_ID;
      endcase
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cmd_ff <= q_cmd;
      end
      if (do_read) begin
         rd_entry_ff  <= table_mem[cmd_ff.idx];
         head_data_ff <= wait_mem[head_ff];
      end
      if (table_we) begin
         table_mem[cmd_ff.idx] <= wr_entry;
      end
      if (wait_we) begin
         wait_mem[tail_ff] <= cmd_ff.thread;
      end
      if (do_exec) begin
         rsp_status_ff        <= res_status;
         rsp_result_id_ff     <= res_rid;
         rsp_count_ff         <= res_count;
         rsp_is_soft_ff       <= res_soft;
         rsp_caller_blocks_ff <= res_blk;
         rsp_wake_valid_ff    <= res_wv;
         rsp_wake_thread_ff   <= res_wt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_IDLE;
         head_ff       <= '0;
         tail_ff       <= '0;
         fill_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         fill_ff       <= fill_in;
         rsp_strobe_ff <= do_exec;
      end
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_result_id     = rsp_result_id_ff;
   assign rsp_count         = rsp_count_ff;
   assign rsp_is_soft       = rsp_is_soft_ff;
   assign rsp_caller_blocks = rsp_caller_blocks_ff;
   assign rsp_wake_valid    = rsp_wake_valid_ff;
   assign rsp_wake_thread   = rsp_wake_thread_ff;

   assert property (@(posedge clock) disable iff (reset)
      32'(fill_ff) <= 32'(WAIT_DEPTH))
      else $error("Wait queue fill exceeds its depth.");
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff) == BK_EXEC)
      else $error("Result strobe without an executed command.");
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_caller_blocks && rsp_wake_valid))
      else $error("One result both blocks and wakes.");
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("Results on consecutive cycles.");

endmodule

// ===== hdl/counting_semaphore_bank_unit.sv =====
// ---------------------------------------------------------------------------
// Flow: an accepted command enters the command queue, then passes the back end's
// dequeue, table read and execute states, and its result is registered in execute;
// the back end takes one command at a time, and a two-entry queue holds commands ahead.
// Results cannot be stalled by the receiver.
// Reset: synchronous; clears the created-id set, the id counter, the wait queue
// pointers and the command queue, but not the table or wait queue contents.
// ---------------------------------------------------------------------------
// Counting semaphore bank
// Bank of counting semaphores with a shared wait queue of thread ids.
// ---------------------------------------------------------------------------
module counting_semaphore_bank_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [csb_pkg::OP_BITS-1:0]           req_op,
   input  logic [csb_pkg::ID_BITS-1:0]           req_sem_id,
   input  logic signed [csb_pkg::VAL_BITS-1:0]   req_max_count,
   input  logic signed [csb_pkg::VAL_BITS-1:0]   req_init_value,
   input  logic                                  req_soft_flag,
   input  logic [csb_pkg::TID_BITS-1:0]          req_thread_id,
   output logic                                  rsp_strobe,
   output logic [csb_pkg::STATUS_BITS-1:0]       rsp_status,
   output logic [csb_pkg::ID_BITS-1:0]           rsp_result_id,
   output logic signed [csb_pkg::VAL_BITS-1:0]   rsp_count,
   output logic                                  rsp_is_soft,
   output logic                                  rsp_caller_blocks,
   output logic                                  rsp_wake_valid,
   output logic [csb_pkg::TID_BITS-1:0]          rsp_wake_thread
);
   import csb_pkg::*;

   logic             accept;
   logic             push;
   logic             pop;
   cmd_type          push_cmd;
   cmd_type          pop_cmd;
   queue_status_type qstat;

   assign busy   = qstat.full;
   assign accept = start && !busy;

   csb_front u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .req_op         (req_op),
      .req_sem_id     (req_sem_id),
      .req_max_count  (req_max_count),
      .req_init_value (req_init_value),
      .req_soft_flag  (req_soft_flag),
      .req_thread_id  (req_thread_id),
      .push           (push),
      .cmd            (push_cmd)
   );

   csb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .qstat    (qstat)
   );

   csb_back u_back (
      .clock             (clock),
      .reset             (reset),
      .qstat             (qstat),
      .q_cmd             (pop_cmd),
      .pop               (pop),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_result_id     (rsp_result_id),
      .rsp_count         (rsp_count),
      .rsp_is_soft       (rsp_is_soft),
      .rsp_caller_blocks (rsp_caller_blocks),
      .rsp_wake_valid    (rsp_wake_valid),
      .rsp_wake_thread   (rsp_wake_thread)
   );

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Counting semaphore bank testbench
// Sends create, up, down and query commands, one beat per start/busy
// handshake, and predicts every result from its own copy of the semaphore
// table and the shared wait queue. It checks each strobed result field by
// field against the oldest outstanding prediction.
// ---------------------------------------------------------------------------
module testbench;
   import csb_pkg::*;

   typedef struct {
      op_type                     op;
      logic [ID_BITS-1:0]         sem_id;
      logic signed [VAL_BITS-1:0] max_count;
      logic signed [VAL_BITS-1:0] init_value;
      logic                       soft_flag;
      logic [TID_BITS-1:0]        thread;
   } sem_command_type;

   typedef struct {
      status_type                 status;
      logic [ID_BITS-1:0]         rid;
      logic [VAL_BITS-1:0]        count;
      logic                       is_soft;
      logic                       blocks;
      logic                       wake;
      logic [TID_BITS-1:0]        wake_thread;
   } sem_reply_type;

   class semaphore_ledger;
      longint                    level [NUM_SEMS];
      longint                    ceiling [NUM_SEMS];
      bit                        lenient [NUM_SEMS];
      bit                        live [NUM_SEMS];
      longint                    count_floor;
      int                        created;
      int                        failures;
      logic [THREAD_ID_BITS-1:0] waiters [$];
      sem_reply_type             replies [$];

      function new();
         foreach (live[i]) begin
            level[i]   = 0;
            ceiling[i] = 0;
            lenient[i] = 0;
            live[i]    = 0;
         end
         count_floor = -(longint'(1) <<< (COUNT_BITS - 1));
         created     = 0;
         failures    = 0;
      endfunction

      static function longint saturate(longint v, int bits);
         longint hi;
         longint lo;
         hi = (longint'(1) <<< (bits - 1)) - 1;
         lo = -hi - 1;
         if (v > hi) begin
            return hi;
         end
         if (v < lo) begin
            return lo;
         end
         return v;
      endfunction

      function void note_command(sem_command_type c);
         sem_reply_type r;
         int            idx;
         r.status      = ST_OK;
         r.rid         = c.sem_id;
         r.count       = '0;
         r.is_soft     = 1'b0;
         r.blocks      = 1'b0;
         r.wake        = 1'b0;
         r.wake_thread = '0;
         idx           = c.sem_id;
         if (c.op == OP_CREATE) begin
            r.rid = '0;
            if (created >= NUM_SEMS) begin
               r.status = ST_TABLE_FULL;
            end else begin
               ceiling[created] = saturate(c.max_count, COUNT_BITS);
               level[created]   = saturate(c.init_value, COUNT_BITS);
               lenient[created] = c.soft_flag;
               live[created]    = 1'b1;
               r.rid     = ID_BITS'(created);
               r.count   = VAL_BITS'(saturate(level[created], VAL_BITS));
               r.is_soft = lenient[created];
               created++;
            end
         end else if (idx >= NUM_SEMS || !live[idx]) begin
            r.status = ST_BAD_ID;
         end else begin
            if (c.op == OP_UP) begin
               if (level[idx] < ceiling[idx]) begin
                  level[idx]++;
               end
               if (!lenient[idx] && level[idx] <= 0) begin
                  if (waiters.size() == 0) begin
                     r.status = ST_QUEUE_EMPTY;
                  end else begin
                     r.wake        = 1'b1;
                     r.wake_thread = TID_BITS'(waiters.pop_front());
                  end
               end
            end else if (c.op == OP_DOWN) begin
               if (level[idx] > count_floor) begin
                  level[idx]--;
               end
               if (!lenient[idx] && level[idx] < 0) begin
                  if (waiters.size() >= WAIT_DEPTH) begin
                     r.status = ST_QUEUE_FULL;
                  end else begin
                     waiters.push_back(c.thread[THREAD_ID_BITS-1:0]);
                     r.blocks = 1'b1;
                  end
               end
            end
            r.count   = VAL_BITS'(saturate(level[idx], VAL_BITS));
            r.is_soft = lenient[idx];
         end
         replies.push_back(r);
      endfunction

      task report(string msg);
         failures++;
         if (failures <= 50) begin
            $display("mismatch at %0t: %s", $realtime, msg);
         end
      endtask

      task compare(string name, logic [31:0] got, logic [31:0] want);
         if (got !== want) begin
            report($sformatf("%s is %0h, expected %0h", name, got, want));
         end
      endtask

      task check_reply(sem_reply_type got);
         sem_reply_type want;
         if (replies.size() == 0) begin
            report("result strobed with no command outstanding");
            return;
         end
         want = replies.pop_front();
         compare("status", got.status, want.status);
         compare("result_id", got.rid, want.rid);
         compare("count", got.count, want.count);
         compare("is_soft", got.is_soft, want.is_soft);
         compare("caller_blocks", got.blocks, want.blocks);
         compare("wake_valid", got.wake, want.wake);
         compare("wake_thread", got.wake_thread, want.wake_thread);
      endtask
   endclass

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic                       busy;
   logic [OP_BITS-1:0]         req_op = '0;
   logic [ID_BITS-1:0]         req_sem_id = '0;
   logic signed [VAL_BITS-1:0] req_max_count = '0;
   logic signed [VAL_BITS-1:0] req_init_value = '0;
   logic                       req_soft_flag = 1'b0;
   logic [TID_BITS-1:0]        req_thread_id = '0;
   logic                       rsp_strobe;
   logic [STATUS_BITS-1:0]     rsp_status;
   logic [ID_BITS-1:0]         rsp_result_id;
   logic signed [VAL_BITS-1:0] rsp_count;
   logic                       rsp_is_soft;
   logic                       rsp_caller_blocks;
   logic                       rsp_wake_valid;
   logic [TID_BITS-1:0]        rsp_wake_thread;

   semaphore_ledger ledger = new();
   sem_reply_type   observed;

   counting_semaphore_bank_unit uut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_op            (req_op),
      .req_sem_id        (req_sem_id),
      .req_max_count     (req_max_count),
      .req_init_value    (req_init_value),
      .req_soft_flag     (req_soft_flag),
      .req_thread_id     (req_thread_id),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_result_id     (rsp_result_id),
      .rsp_count         (rsp_count),
      .rsp_is_soft       (rsp_is_soft),
      .rsp_caller_blocks (rsp_caller_blocks),
      .rsp_wake_valid    (rsp_wake_valid),
      .rsp_wake_thread   (rsp_wake_thread)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) begin
         observed.status      = status_type'(rsp_status);
         observed.rid         = rsp_result_id;
         observed.count       = rsp_count;
         observed.is_soft     = rsp_is_soft;
         observed.blocks      = rsp_caller_blocks;
         observed.wake        = rsp_wake_valid;
         observed.wake_thread = rsp_wake_thread;
         ledger.check_reply(observed);
      end
   end

   task automatic issue(sem_command_type c, bit may_idle);
      req_op         <= c.op;
      req_sem_id     <= c.sem_id;
      req_max_count  <= c.max_count;
      req_init_value <= c.init_value;
      req_soft_flag  <= c.soft_flag;
      req_thread_id  <= c.thread;
      start          <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      ledger.note_command(c);
      if (may_idle && $urandom_range(99) < 36) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic cmd(op_type op, int id, int max_v, int init_v, bit sft, int thr);
      sem_command_type c;
      c.op         = op;
      c.sem_id     = ID_BITS'(id);
      c.max_count  = VAL_BITS'(max_v);
      c.init_value = VAL_BITS'(init_v);
      c.soft_flag  = sft;
      c.thread     = TID_BITS'(thr);
      issue(c, 1'b1);
   endtask

   function automatic int pick_live(bit prefer_hard);
      int id;
      if (ledger.created == 0) begin
         return 0;
      end
      id = $urandom_range(ledger.created - 1);
      for (int k = 0; k < 4 && prefer_hard && ledger.lenient[id]; k++) begin
         id = $urandom_range(ledger.created - 1);
      end
      return id;
   endfunction

   task automatic random_item(int create_w, int bad_w, int up_w, int down_w, bit may_idle);
      sem_command_type c;
      int              r;
      int              id;
      r            = $urandom_range(99);
      c.max_count  = VAL_BITS'($urandom);
      c.init_value = VAL_BITS'($urandom);
      c.soft_flag  = $urandom_range(1);
      c.thread     = TID_BITS'($urandom);
      c.op         = OP_QUERY;
      id           = pick_live(1'b0);
      if (r < create_w) begin
         c.op = OP_CREATE;
         c.soft_flag = ($urandom_range(3) == 0);
         if ($urandom_range(3) != 0) begin
            c.max_count  = VAL_BITS'(int'($urandom_range(10)) - 2);
            c.init_value = VAL_BITS'(int'($urandom_range(8)) - 4);
         end
      end else if (r < create_w + bad_w) begin
         c.op = op_type'($urandom_range(OP_UP, OP_QUERY));
         if (ledger.created < NUM_SEMS) begin
            id = $urandom_range(2 ** ID_BITS - 1, ledger.created);
         end
      end else if (r < create_w + bad_w + up_w) begin
         c.op = OP_UP;
         id = pick_live(1'b1);
      end else if (r < create_w + bad_w + up_w + down_w) begin
         c.op = OP_DOWN;
         id = pick_live(1'b1);
      end
      c.sem_id = ID_BITS'(id);
      issue(c, may_idle);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Commands to ids that were never created.
      cmd(OP_QUERY, 0, 0, 0, 0, 0);
      cmd(OP_UP, 63, 0, 0, 0, 0);
      cmd(OP_DOWN, 5, 0, 0, 0, 0);
      // Count pinned at the top of the range.
      cmd(OP_CREATE, 0, 32767, 32767, 0, 0);
      cmd(OP_UP, 0, 0, 0, 0, 0);
      // Count at the bottom of the range, then a wake with an empty queue.
      cmd(OP_CREATE, 0, -32768, -32768, 0, 0);
      cmd(OP_DOWN, 1, 0, 0, 0, 8'hFF);
      cmd(OP_UP, 1, 0, 0, 0, 0);
      cmd(OP_UP, 1, 0, 0, 0, 0);
      // A soft semaphore never blocks or wakes.
      cmd(OP_CREATE, 0, 5, 0, 1, 0);
      cmd(OP_DOWN, 2, 0, 0, 0, 8'h5A);
      cmd(OP_UP, 2, 0, 0, 0, 0);
      // Two waiters released in arrival order.
      cmd(OP_CREATE, 0, 3, 0, 0, 0);
      cmd(OP_DOWN, 3, 0, 0, 0, 8'h00);
      cmd(OP_DOWN, 3, 0, 0, 0, 8'hA5);
      cmd(OP_QUERY, 3, 0, 0, 0, 0);
      cmd(OP_UP, 3, 0, 0, 0, 0);
      cmd(OP_UP, 3, 0, 0, 0, 0);
      cmd(OP_UP, 3, 0, 0, 0, 0);
      cmd(OP_CREATE, 0, 100, -5, 0, 0);
      cmd(OP_UP, 4, 0, 0, 0, 0);
      // Ceiling below the starting count.
      cmd(OP_CREATE, 0, -5, 10, 0, 0);
      cmd(OP_UP, 5, 0, 0, 0, 0);
      cmd(OP_DOWN, 5, 0, 0, 0, 8'h3C);
      cmd(OP_QUERY, 6, 0, 0, 0, 0);

      // Fill the table, then flood the wait queue, then drain it past empty.
      for (int n = 0; n < 400; n++) begin
         if (n < 100) begin
            random_item(55, 10, 8, 8, 1'b1);
         end else if (n < 250) begin
            random_item(5, 3, 5, 85, !(n < 200));
         end else if (n < 370) begin
            random_item(5, 3, 85, 5, 1'b1);
         end else begin
            random_item(25, 10, 25, 25, 1'b1);
         end
      end

      start <= 1'b0;
      while (ledger.replies.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (ledger.failures == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

   initial begin
      #200000;
      $display("testbench: FAIL");
      $finish;
   end

endmodule
